@@ design/ehx_pkg.sv @@
// Shared constants and result type for the Ethernet header extractor.
package ehx_pkg;

    localparam int          MAX_FRAME_BYTES_DEF = 2048;
    localparam int          OFFSET_W            = 11;
    localparam int          TDATA_W             = 408;
    localparam int          TUSER_W             = 4;

    localparam logic [10:0] OFFSET_MAX = 11'd2047;

    localparam logic [15:0] KIND_ARP   = 16'h0806;
    localparam logic [15:0] KIND_IPV4  = 16'h0800;
    localparam logic [15:0] KIND_IPV6  = 16'h86dd;

    localparam logic [3:0]  IHL_MIN         = 4'd5;
    localparam logic [11:0] ETH_HDR_BYTES   = 12'd14;
    localparam logic [11:0] ARP_MIN_BYTES   = 12'd42;
    localparam logic [11:0] IPV6_MIN_BYTES  = 12'd58;
    localparam logic [10:0] IPV4_PROTO_POS  = 11'd23;
    localparam logic [10:0] IPV6_PROTO_POS  = 11'd20;
    localparam logic [10:0] IPV6_PORT_BASE  = 11'd54;

    localparam logic [2:0]  CLS_ARP   = 3'd0;
    localparam logic [2:0]  CLS_IPV4  = 3'd1;
    localparam logic [2:0]  CLS_IPV6  = 3'd2;
    localparam logic [2:0]  CLS_OTHER = 3'd3;
    localparam logic [2:0]  CLS_TRUNC = 3'd4;

    typedef struct packed {
        logic [2:0]  frame_class;
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [63:0] source_ip_high;
        logic [63:0] source_ip_low;
        logic [63:0] dest_ip_high;
        logic [63:0] dest_ip_low;
        logic [7:0]  ip_protocol;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic        ports_valid;
        logic [10:0] frame_length;
    } t_result;

endpackage

@@ design/ethernet_ip_header_extractor_core.sv @@
// Top level of the Ethernet/ARP/IPv4/IPv6 header extractor with output buffering.
// Takes one frame byte per cycle on the slave stream while tready is high
// (tlast on the final byte) and emits one header summary per frame on the
// master stream, registered once the last byte is accepted. Capture and
// classification are a single pass of logic into the per-frame state and the
// result register. Results go through a two-entry output buffer (result
// register plus skid register), so tready on the input is a register and only
// drops when both entries hold results that the sink has not taken.
module ethernet_ip_header_extractor_core
    import ehx_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,  // data_byte[7:0]
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // dest_mac[47:0], source_mac[95:48], source_ip_high[159:96],
    // source_ip_low[223:160], dest_ip_high[287:224], dest_ip_low[351:288],
    // ip_protocol[359:352], source_port[375:360], dest_port[391:376],
    // frame_length[402:392], zero pad[407:403]
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [TUSER_W-1:0] m_axis_tuser   // frame_class[2:0], ports_valid[3]
);

    logic    accept;
    logic    res_valid;
    t_result res;

    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    out_free;

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ehx_parse #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= res_valid;
                    if (res_valid) begin
                        r_skid <= res;
                    end
                end else begin
                    r_out_valid <= res_valid;
                    if (res_valid) begin
                        r_out <= res;
                    end
                end
            end else if (res_valid) begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.frame_length, r_out.dest_port, r_out.source_port,
                            r_out.ip_protocol, r_out.dest_ip_low, r_out.dest_ip_high,
                            r_out.source_ip_low, r_out.source_ip_high,
                            r_out.source_mac, r_out.dest_mac};
    assign m_axis_tuser  = {r_out.ports_valid, r_out.frame_class};

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a result in the output register");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready && accept && s_axis_tlast) |=> r_skid_valid)
        else $error("result on a stalled output was not parked in the skid entry");

    a_ports_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[3]) |->
            (m_axis_tuser[2:0] == CLS_IPV4 || m_axis_tuser[2:0] == CLS_IPV6))
        else $error("ports flagged valid on a frame that is not IPv4 or IPv6");

endmodule

@@ design/ehx_parse.sv @@
// Per-frame header capture state and end-of-frame summary logic.
module ehx_parse
    import ehx_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int          LEN_LIM = (MAX_FRAME_BYTES < 2048) ? MAX_FRAME_BYTES : 2048;
    localparam logic [10:0] LEN_MAX = 11'(LEN_LIM - 1);

    logic [10:0] r_offset, n_offset;
    logic [15:0] r_kind,   n_kind;
    logic [3:0]  r_ihl,    n_ihl;
    logic [47:0] r_mac  [2];
    logic [47:0] n_mac  [2];
    logic [63:0] r_addr [4];
    logic [63:0] n_addr [4];
    logic [7:0]  r_proto,  n_proto;
    logic [15:0] r_port [2];
    logic [15:0] n_port [2];

    logic [10:0] pos;
    logic [10:0] port_base;
    logic [3:0]  ihl_cap;
    logic [3:0]  ihl_end;
    logic [11:0] bytes;
    logic [11:0] ipv4_need;
    logic        ip_fields;
    logic        ports;
    logic        high;
    logic [2:0]  cls;

    assign pos     = r_offset;
    assign ihl_cap = (r_ihl < IHL_MIN) ? IHL_MIN : r_ihl;
    assign ihl_end = (n_ihl < IHL_MIN) ? IHL_MIN : n_ihl;

    always_comb begin
        n_offset  = r_offset;
        n_kind    = r_kind;
        n_ihl     = r_ihl;
        n_mac     = r_mac;
        n_addr    = r_addr;
        n_proto   = r_proto;
        n_port    = r_port;
        port_base = IPV6_PORT_BASE;
        if (i_accept) begin
            if (pos < 11'd6) begin
                n_mac[0] = {r_mac[0][39:0], i_byte};
            end else if (pos < 11'd12) begin
                n_mac[1] = {r_mac[1][39:0], i_byte};
            end else if (pos < 11'd14) begin
                n_kind = {r_kind[7:0], i_byte};
            end else begin
                if (pos == 11'd14) begin
                    n_ihl = i_byte[3:0];
                end
                case (r_kind)
                    KIND_ARP: begin
                        if (pos >= 11'd28 && pos < 11'd32) begin
                            n_addr[1] = {r_addr[1][55:0], i_byte};
                        end else if (pos >= 11'd38 && pos < 11'd42) begin
                            n_addr[3] = {r_addr[3][55:0], i_byte};
                        end
                    end
                    KIND_IPV4: begin
                        port_base = 11'd14 + {5'd0, ihl_cap, 2'b00};
                        if (pos == IPV4_PROTO_POS) begin
                            n_proto = i_byte;
                        end else if (pos >= 11'd26 && pos < 11'd30) begin
                            n_addr[1] = {r_addr[1][55:0], i_byte};
                        end else if (pos >= 11'd30 && pos < 11'd34) begin
                            n_addr[3] = {r_addr[3][55:0], i_byte};
                        end
                        if (pos > 11'd14) begin
                            if (pos >= port_base && pos < port_base + 11'd2) begin
                                n_port[0] = {r_port[0][7:0], i_byte};
                            end else if (pos >= port_base + 11'd2
                                         && pos < port_base + 11'd4) begin
                                n_port[1] = {r_port[1][7:0], i_byte};
                            end
                        end
                    end
                    KIND_IPV6: begin
                        if (pos == IPV6_PROTO_POS) begin
                            n_proto = i_byte;
                        end else if (pos >= 11'd22 && pos < 11'd30) begin
                            n_addr[0] = {r_addr[0][55:0], i_byte};
                        end else if (pos >= 11'd30 && pos < 11'd38) begin
                            n_addr[1] = {r_addr[1][55:0], i_byte};
                        end else if (pos >= 11'd38 && pos < 11'd46) begin
                            n_addr[2] = {r_addr[2][55:0], i_byte};
                        end else if (pos >= 11'd46 && pos < 11'd54) begin
                            n_addr[3] = {r_addr[3][55:0], i_byte};
                        end
                        if (pos >= port_base && pos < port_base + 11'd2) begin
                            n_port[0] = {r_port[0][7:0], i_byte};
                        end else if (pos >= port_base + 11'd2
                                     && pos < port_base + 11'd4) begin
                            n_port[1] = {r_port[1][7:0], i_byte};
                        end
                    end
                    default: ;
                endcase
            end
            if (r_offset != OFFSET_MAX) begin
                n_offset = r_offset + 11'd1;
            end
        end
    end

    // summary uses the state as it stands after this byte
    assign bytes     = {1'b0, pos} + 12'd1;
    assign ipv4_need = 12'd18 + {6'd0, ihl_end, 2'b00};

    always_comb begin
        ip_fields = 1'b0;
        ports     = 1'b0;
        high      = 1'b0;
        if (bytes < ETH_HDR_BYTES) begin
            cls = CLS_TRUNC;
        end else begin
            case (n_kind)
                KIND_ARP: begin
                    cls       = (bytes < ARP_MIN_BYTES) ? CLS_TRUNC : CLS_ARP;
                    ip_fields = 1'b1;
                end
                KIND_IPV4: begin
                    cls       = (bytes < ipv4_need) ? CLS_TRUNC : CLS_IPV4;
                    ip_fields = 1'b1;
                    ports     = 1'b1;
                end
                KIND_IPV6: begin
                    cls       = (bytes < IPV6_MIN_BYTES) ? CLS_TRUNC : CLS_IPV6;
                    ip_fields = 1'b1;
                    ports     = 1'b1;
                    high      = 1'b1;
                end
                default: cls = CLS_OTHER;
            endcase
        end
        if (cls == CLS_TRUNC) begin
            ip_fields = 1'b0;
            ports     = 1'b0;
            high      = 1'b0;
        end
    end

    always_comb begin
        o_res.frame_class    = cls;
        o_res.dest_mac       = n_mac[0];
        o_res.source_mac     = n_mac[1];
        o_res.source_ip_high = (ip_fields && high) ? n_addr[0] : 64'd0;
        o_res.source_ip_low  = ip_fields ? n_addr[1] : 64'd0;
        o_res.dest_ip_high   = (ip_fields && high) ? n_addr[2] : 64'd0;
        o_res.dest_ip_low    = ip_fields ? n_addr[3] : 64'd0;
        o_res.ip_protocol    = ports ? n_proto : 8'd0;
        o_res.source_port    = ports ? n_port[0] : 16'd0;
        o_res.dest_port      = ports ? n_port[1] : 16'd0;
        o_res.ports_valid    = ports;
        o_res.frame_length   = (bytes > {1'b0, LEN_MAX}) ? LEN_MAX : bytes[10:0];
    end

    assign o_res_valid = i_accept && i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_offset <= '0;
            r_kind   <= '0;
            r_ihl    <= '0;
            r_mac    <= '{default: '0};
            r_addr   <= '{default: '0};
            r_proto  <= '0;
            r_port   <= '{default: '0};
        end else begin
            r_offset <= n_offset;
            r_kind   <= n_kind;
            r_ihl    <= n_ihl;
            r_mac    <= n_mac;
            r_addr   <= n_addr;
            r_proto  <= n_proto;
            r_port   <= n_port;
        end
    end

endmodule
